### sv/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg: shared types and constants for the framed record checker
// Item and result structures, status codes, FNV-1a constants and step function.
// ----------------------------------------------------------------------------
package fcf_pkg;

  // FNV-1a constants and header size.
  localparam logic [31:0] FNV_BASIS    = 32'h811c_9dc5;
  localparam logic [31:0] FNV_PRIME    = 32'h0100_0193;
  localparam logic [4:0]  HEADER_BYTES = 5'd16;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_MAGIC    = 3'd2;
  localparam logic [2:0] ST_VERSION  = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_VERSION = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [31:0] MAGIC_RESET   = 32'h5941_504c;
  localparam logic [31:0] VERSION_RESET = 32'd1;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } fcf_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] payload_length;
    logic [31:0] computed_hash;
  } fcf_result_t;

  // One FNV-1a step. The prime is 2^24 + 0x193, so the product is a shift-add sum.
  function automatic logic [31:0] fnv_step(input logic [31:0] hash, input logic [7:0] b);
    logic [31:0] x;
    begin
      x = hash ^ {24'd0, b};
      fnv_step = x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
    end
  endfunction

endpackage

### sv/fcf_in_stage.sv
// ----------------------------------------------------------------------------
// fcf_in_stage: input register
// Takes one item per cycle unless stalled; holds it until the core takes it.
// ----------------------------------------------------------------------------
module fcf_in_stage
  import fcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  fcf_item_t in_item,
  input  logic      advance,
  output logic      item_valid,
  output fcf_item_t item
);

  logic      valid_r;
  logic      valid_nxt;
  fcf_item_t item_r;

  // The register is free when empty or when its item moves on this cycle.
  assign in_stall   = valid_r && !advance;
  assign valid_nxt  = in_valid ? 1'b1 : (valid_r && !advance);
  assign item_valid = valid_r;
  assign item       = item_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads on every accepted item.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

### sv/fcf_core.sv
// ----------------------------------------------------------------------------
// fcf_core: header parser and payload hasher
// Holds the frame state and does one byte of work per fired item.
// ----------------------------------------------------------------------------
module fcf_core
  import fcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  fcf_item_t   item,
  input  logic [31:0] expected_magic,
  input  logic [31:0] expected_version,
  output logic        emit,
  output fcf_result_t result
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  logic [1:0]  phase_r,   phase_nxt;
  logic [4:0]  hdr_idx_r, hdr_idx_nxt;
  logic [31:0] word_r,    word_nxt;
  logic        magic_r,   magic_nxt;
  logic        ver_r,     ver_nxt;
  logic [31:0] len_r,     len_nxt;
  logic [31:0] sum_r,     sum_nxt;
  logic [31:0] left_r,    left_nxt;
  logic [31:0] hash_r,    hash_nxt;

  logic [1:0]  pos;
  logic [4:0]  idx_inc;
  logic [31:0] assembled;
  logic        eob;
  logic        rearm;

  assign pos       = hdr_idx_r[1:0];
  assign idx_inc   = hdr_idx_r + 5'd1;
  assign assembled = word_r | ({24'd0, item.data_byte} << {pos, 3'b000});
  assign eob       = item.end_of_buffer;

  // Next-state and result logic for one byte.
  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    word_nxt    = word_r;
    magic_nxt   = magic_r;
    ver_nxt     = ver_r;
    len_nxt     = len_r;
    sum_nxt     = sum_r;
    left_nxt    = left_r;
    hash_nxt    = hash_r;
    emit        = 1'b0;
    rearm       = 1'b0;
    result      = '0;

    case (phase_r)
      PH_HEADER: begin
        word_nxt    = assembled;
        hdr_idx_nxt = idx_inc;
        // A word completes on every fourth byte.
        if (pos == 2'd3) begin
          word_nxt = '0;
          case (idx_inc)
            5'd4:    magic_nxt = (assembled == expected_magic);
            5'd8:    ver_nxt   = (assembled == expected_version);
            5'd12:   len_nxt   = assembled;
            default: sum_nxt   = assembled;
          endcase
        end
        if (idx_inc < HEADER_BYTES) begin
          if (eob) begin
            emit          = 1'b1;
            rearm         = 1'b1;
            result.status = ST_SHORT;
          end
        end else begin
          // Header complete: checks in priority order.
          result.payload_length = len_nxt;
          if (!magic_nxt) begin
            emit          = 1'b1;
            rearm         = eob;
            result.status = ST_MAGIC;
          end else if (!ver_nxt) begin
            emit          = 1'b1;
            rearm         = eob;
            result.status = ST_VERSION;
          end else if (len_nxt == 32'd0) begin
            emit          = 1'b1;
            rearm         = eob;
            result.status = (hash_r == sum_nxt) ? ST_OK : ST_MISMATCH;
          end else if (eob) begin
            emit          = 1'b1;
            rearm         = 1'b1;
            result.status = ST_TRUNC;
          end else begin
            left_nxt  = len_nxt;
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        hash_nxt              = fnv_step(hash_r, item.data_byte);
        left_nxt              = left_r - 32'd1;
        result.payload_length = len_r;
        if (left_nxt == 32'd0) begin
          emit          = 1'b1;
          rearm         = eob;
          result.status = (hash_nxt == sum_r) ? ST_OK : ST_MISMATCH;
        end else if (eob) begin
          emit          = 1'b1;
          rearm         = 1'b1;
          result.status = ST_TRUNC;
        end
      end
      default: begin
        // Done, or a stray code: ignore bytes until the buffer ends.
        rearm = eob;
      end
    endcase

    result.computed_hash = hash_nxt;

    // After a result the block waits for the buffer end or rearms now.
    if (emit && !rearm) begin
      phase_nxt = PH_DONE;
    end
    if (rearm) begin
      phase_nxt   = PH_HEADER;
      hdr_idx_nxt = '0;
      word_nxt    = '0;
      magic_nxt   = 1'b0;
      ver_nxt     = 1'b0;
      len_nxt     = '0;
      sum_nxt     = '0;
      left_nxt    = '0;
      hash_nxt    = FNV_BASIS;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_idx_r <= '0;
      word_r    <= '0;
      magic_r   <= 1'b0;
      ver_r     <= 1'b0;
      len_r     <= '0;
      sum_r     <= '0;
      left_r    <= '0;
      hash_r    <= FNV_BASIS;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      word_r    <= word_nxt;
      magic_r   <= magic_nxt;
      ver_r     <= ver_nxt;
      len_r     <= len_nxt;
      sum_r     <= sum_nxt;
      left_r    <= left_nxt;
      hash_r    <= hash_nxt;
    end
  end

endmodule

### sv/fcf_out_stage.sv
// ----------------------------------------------------------------------------
// fcf_out_stage: result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module fcf_out_stage
  import fcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        emit,
  input  fcf_result_t result,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output fcf_result_t out_result
);

  logic        valid_r;
  fcf_result_t result_r;

  // The core may run when the register is empty or is drained this cycle.
  assign advance    = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= fire && emit;
    end
  end

  // Payload loads whenever a new result is produced.
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result_r <= result;
    end
  end

endmodule

### sv/framed_record_checker_fnv.sv
// ----------------------------------------------------------------------------
// framed_record_checker_fnv: framed record checker with FNV-1a payload hash
// Parses a 16-byte header, hashes the payload and reports one status per frame.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_stall does not hold the result register;
// the hash step is one xor and a shift-add multiply.
// The input register and the result register let a new item enter while a result waits.
// Reset (synchronous, rst_n low) empties both registers, rearms the frame parser
// and restores the magic and version registers to their reset values.
module framed_record_checker_fnv
  import fcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_payload_length,
  output logic [31:0] out_computed_hash,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] magic_r;
  logic [31:0] version_r;
  fcf_item_t   in_item;
  fcf_item_t   item;
  logic        item_valid;
  logic        advance;
  logic        fire;
  logic        emit;
  fcf_result_t result;
  fcf_result_t out_result;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MAGIC_RESET;
      version_r <= VERSION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAGIC:   magic_r   <= cfg_data;
        CFG_VERSION: version_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign in_item.data_byte     = in_data_byte;
  assign in_item.end_of_buffer = in_end_of_buffer;
  assign fire                  = item_valid && advance;

  fcf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  fcf_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .item             (item),
    .expected_magic   (magic_r),
    .expected_version (version_r),
    .emit             (emit),
    .result           (result)
  );

  fcf_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .emit       (emit),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_status         = out_result.status;
  assign out_payload_length = out_result.payload_length;
  assign out_computed_hash  = out_result.computed_hash;

endmodule

### sv/fcf_checker.sv
// ----------------------------------------------------------------------------
// fcf_checker: port-level checks for the framed record checker
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module fcf_checker
  import fcf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_payload_length,
  input logic [31:0] out_computed_hash
);

  // A stalled result item stays valid.
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_payload_length)
      && $stable(out_computed_hash))
    else $error("result item changed while stalled");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_MISMATCH)
    else $error("undefined status code");

  // A short header carries no length and no hashed bytes.
  a_short_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SHORT |->
      out_payload_length == 32'd0 && out_computed_hash == FNV_BASIS)
    else $error("short header result carries header or hash data");

  // Header faults are judged before any payload byte is hashed.
  a_header_fault_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MAGIC || out_status == ST_VERSION) |->
      out_computed_hash == FNV_BASIS)
    else $error("header fault result carries a payload hash");

endmodule

bind framed_record_checker_fnv fcf_checker u_fcf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_payload_length (out_payload_length),
  .out_computed_hash  (out_computed_hash)
);
